// ===== sv/utsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package utsd_pkg;

  localparam int unsigned RunMax = 4;
  localparam int unsigned CntW   = 3;
  localparam int unsigned IdxW   = 2;

  localparam logic [7:0]  BomByte0 = 8'hEF;
  localparam logic [7:0]  BomByte1 = 8'hBB;
  localparam logic [7:0]  BomByte2 = 8'hBF;
  localparam logic [15:0] QMark    = 16'h003F;
  localparam logic [15:0] TermUnit = 16'h0000;

  typedef logic [15:0] unit_t;
  typedef unit_t [RunMax-1:0] run_t;

  typedef struct packed {
    logic [7:0] l0;
    logic [7:0] l1;
    logic [1:0] held;
    logic       start;
  } dec_state_t;

  localparam dec_state_t StateReset = '{l0: 8'h00, l1: 8'h00, held: 2'd0, start: 1'b1};

  typedef struct packed {
    logic  valid;
    unit_t code;
  } unit_res_t;

  typedef struct packed {
    logic [CntW-1:0] left;
    logic            take_next;
  } emit_status_t;

  function automatic unit_res_t decode_byte(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
    unit_res_t r;
    r.valid = 1'b1;
    r.code  = '0;
    if (!b0[7]) begin
      r.code = {8'h00, b0};
    end else if (b0[7:6] == 2'b10) begin
      r.valid = 1'b0;
    end else if (b0[7:5] == 3'b110) begin
      r.code = {5'b00000, b0[4:0], b1[5:0]};
    end else if (b0[7:4] == 4'hE) begin
      r.code = {b0[3:0], b1[5:0], b2[5:0]};
    end else begin
      r.code = QMark;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/utsd_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
module utsd_decode (
  input  wire utsd_pkg::dec_state_t      state_i,
  input  wire logic [7:0]                in_byte_i,
  input  wire logic                      end_of_string_i,
  output utsd_pkg::dec_state_t           state_next_o,
  output utsd_pkg::run_t                 units_o,
  output logic [utsd_pkg::CntW-1:0]      cnt_o
);
  import utsd_pkg::*;

  dec_state_t           st;
  unit_res_t [RunMax-1:0] slot;
  unit_res_t            fa;
  unit_res_t            fb;
  logic                 bom;
  logic [7:0]           fa_b1;

  always_comb begin
    st      = state_i;
    slot[0] = '0;
    bom     = state_i.start && (state_i.l0 == BomByte0) && (state_i.l1 == BomByte1) &&
              (in_byte_i == BomByte2);
    if (state_i.held == 2'd2) begin
      st.start = 1'b0;
      if (bom) begin
        st.l0   = 8'h00;
        st.l1   = 8'h00;
        st.held = 2'd0;
      end else begin
        slot[0] = decode_byte(state_i.l0, state_i.l1, in_byte_i);
        st.l0   = state_i.l1;
        st.l1   = in_byte_i;
      end
    end else begin
      if (state_i.held[0]) begin
        st.l1 = in_byte_i;
      end else begin
        st.l0 = in_byte_i;
      end
      st.held = state_i.held + 2'd1;
    end

    // end-of-string flush, missing lookahead reads as zero
    fa_b1 = (st.held == 2'd2) ? st.l1 : 8'h00;
    fa    = decode_byte(st.l0, fa_b1, 8'h00);
    fb    = decode_byte(st.l1, 8'h00, 8'h00);
    slot[1]       = fa;
    slot[1].valid = fa.valid && end_of_string_i && (st.held != 2'd0);
    slot[2]       = fb;
    slot[2].valid = fb.valid && end_of_string_i && (st.held == 2'd2);
    slot[3].valid = end_of_string_i;
    slot[3].code  = TermUnit;

    state_next_o = end_of_string_i ? StateReset : st;
  end

  always_comb begin
    units_o = '0;
    cnt_o   = '0;
    for (int i = 0; i < RunMax; i++) begin
      if (slot[i].valid) begin
        units_o[cnt_o[IdxW-1:0]] = slot[i].code;
        cnt_o                    = cnt_o + CntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/utsd_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none
module utsd_emit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      load_i,
  input  wire utsd_pkg::run_t            units_i,
  input  wire logic [utsd_pkg::CntW-1:0] cnt_i,
  output utsd_pkg::emit_status_t         status_o,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [15:0]                    code_unit_o,
  output logic                           last_of_run_o
);
  import utsd_pkg::*;

  run_t            run_q;
  logic [CntW-1:0] left_q, left_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  unit_t           code_q;
  logic            last_q;
  logic            out_free;
  logic            pending;
  logic            move;
  logic            take_next;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign pending   = (left_q != '0);
  assign move      = pending && out_free;
  assign take_next = !pending || (move && (left_q == CntW'(1)));

  always_comb begin
    left_d      = left_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = pending;
    end
    if (move) begin
      left_d = left_q - CntW'(1);
      idx_d  = idx_q + IdxW'(1);
    end
    if (load_i && take_next) begin
      left_d = cnt_i;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      left_q      <= left_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && take_next) begin
      run_q <= units_i;
    end
    if (move) begin
      code_q <= run_q[idx_q];
      last_q <= (left_q == CntW'(1));
    end
  end

  assign status_o.left      = left_q;
  assign status_o.take_next = take_next;
  assign out_valid_o        = out_valid_q;
  assign code_unit_o        = code_q;
  assign last_of_run_o      = last_q;

endmodule
`default_nettype wire

// ===== sv/utsd_state.sv =====
`timescale 1ns / 1ps
`default_nettype none
module utsd_state (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire utsd_pkg::dec_state_t state_d_i,
  output utsd_pkg::dec_state_t      state_q_o
);
  import utsd_pkg::*;

  dec_state_t state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (en_i) begin
      state_q <= state_d_i;
    end
  end

  assign state_q_o = state_q;

endmodule
`default_nettype wire

// ===== sv/utf8_to_ucs2_stream_decoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// UTF-8 to 16-bit code unit stream decoder.
// Input channel: one string byte per beat (in_byte_i) with end_of_string_i on
// the final byte. Output channel: one code unit per beat, last_of_run_o set on
// the final unit caused by an input byte. Both channels use valid/stall.
// A byte is decoded once the two following bytes are held, so output lags the
// string by two bytes; the end-of-string byte flushes the held bytes and then
// emits a zero terminator. A leading EF BB BF is dropped.
// Each byte's units are captured into the run buffer at the edge that accepts
// it and moved one by one into the output register whenever that is free.
// Throughput: one byte per cycle while each byte yields at most one unit and
// the output is not stalled; a byte yielding several units (up to four at end
// of string) stalls the input while the single output register drains the
// run buffer.
// Reset clears the lookahead, the run buffer count and the output valid, and
// arms BOM detection. A stall on the output holds the output beat; once the run
// buffer is not about to drain, in_stall_o is raised.
module utf8_to_ucs2_stream_decoder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        end_of_string_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      code_unit_o,
  output logic             last_of_run_o
);
  import utsd_pkg::*;

  dec_state_t      state_q;
  dec_state_t      state_d;
  run_t            units;
  logic [CntW-1:0] cnt;
  emit_status_t    emit_st;
  logic            in_acc;

  assign in_stall_o = !emit_st.take_next;
  assign in_acc     = in_valid_i && emit_st.take_next;

  utsd_state u_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (in_acc),
    .state_d_i (state_d),
    .state_q_o (state_q)
  );

  utsd_decode u_decode (
    .state_i         (state_q),
    .in_byte_i       (in_byte_i),
    .end_of_string_i (end_of_string_i),
    .state_next_o    (state_d),
    .units_o         (units),
    .cnt_o           (cnt)
  );

  utsd_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (in_valid_i),
    .units_i       (units),
    .cnt_i         (cnt),
    .status_o      (emit_st),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .code_unit_o   (code_unit_o),
    .last_of_run_o (last_of_run_o)
  );

  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.held != 2'd3)
    else $error("lookahead count out of range");

  a_eos_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && end_of_string_i |=> state_q.held == 2'd0 && state_q.start)
    else $error("state not reset after end of string");

  a_run_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_st.left > CntW'(1) |-> in_stall_o)
    else $error("input taken while run buffer busy");

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_st.left <= CntW'(RunMax))
    else $error("run buffer count out of range");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import utsd_pkg::*;

  localparam int Predicted = -1;
  localparam int IdleLimit = 2000;
  localparam int RandomBytes = 125;
  localparam int DrainCycles = 20;

  typedef struct {
    logic [15:0] code;
    logic        last;
  } unit_beat_t;

  typedef struct {
    logic [7:0]       b;
    logic             eos;
    int               n;
    logic [3:0][15:0] u;
  } byte_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  in_byte_i;
  logic        end_of_string_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [15:0] code_unit_o;
  logic        last_of_run_o;

  utf8_to_ucs2_stream_decoder_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_byte_i       (in_byte_i),
    .end_of_string_i (end_of_string_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .code_unit_o     (code_unit_o),
    .last_of_run_o   (last_of_run_o)
  );

  always #10 clk_i = ~clk_i;

  // decoder image: two held bytes, oldest in held0
  logic [7:0] held0, held1;
  logic [1:0] held_cnt;
  logic       bom_armed;

  unit_beat_t pending_units[$];
  byte_row_t  byte_table[$];
  logic [7:0] str_bytes[$];
  unit_beat_t want;

  int  errors = 0;
  int  units_checked = 0;
  int  bytes_sent = 0;
  int  strings_sent = 0;
  int  idle_cycles = 0;
  bit  quiet_phase = 1'b0;

  function automatic bit char_of(input logic [7:0] b0, input logic [7:0] b1,
                                 input logic [7:0] b2, output logic [15:0] u);
    u = 16'h0000;
    if (b0 < 8'd128) begin
      u = {8'h00, b0};
    end else if ((b0 & 8'd192) == 8'd128) begin
      return 1'b0;
    end else if ((b0 & 8'd224) == 8'd192) begin
      u = {5'b00000, b0[4:0], b1[5:0]};
    end else if ((b0 & 8'd240) == 8'd224) begin
      u = {b0[3:0], b1[5:0], b2[5:0]};
    end else begin
      u = QMark;
    end
    return 1'b1;
  endfunction

  function automatic int decode_byte_in(input logic [7:0] nb, input logic eos,
                                        output logic [3:0][15:0] units);
    int n;
    bit ok;
    logic [15:0] u;
    logic [7:0] f1;
    n = 0;
    units = '0;
    if (held_cnt >= 2'd2) begin
      if (bom_armed && held0 == BomByte0 && held1 == BomByte1 && nb == BomByte2) begin
        held0 = 8'h00;
        held1 = 8'h00;
        held_cnt = 2'd0;
      end else begin
        ok = char_of(held0, held1, nb, u);
        if (ok) begin
          units[n] = u;
          n++;
        end
        held0 = held1;
        held1 = nb;
        held_cnt = 2'd2;
      end
      bom_armed = 1'b0;
    end else begin
      if (held_cnt[0]) held1 = nb;
      else held0 = nb;
      held_cnt = held_cnt + 2'd1;
    end
    if (eos) begin
      while (held_cnt > 2'd0) begin
        f1 = (held_cnt >= 2'd2) ? held1 : 8'h00;
        ok = char_of(held0, f1, 8'h00, u);
        if (ok) begin
          units[n] = u;
          n++;
        end
        held0 = held1;
        held1 = 8'h00;
        held_cnt = held_cnt - 2'd1;
      end
      units[n] = TermUnit;
      n++;
      held0 = 8'h00;
      held1 = 8'h00;
      held_cnt = 2'd0;
      bom_armed = 1'b1;
    end
    return n;
  endfunction

  function automatic int idle_len();
    int r;
    r = int'($urandom_range(0, 99));
    if (quiet_phase || r < 55) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 30));
  endfunction

  function automatic logic [7:0] rand_byte(input int lo, input int hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  function automatic void add_row(input logic [7:0] b, input logic eos, input int n,
                                  input logic [15:0] u0, input logic [15:0] u1,
                                  input logic [15:0] u2, input logic [15:0] u3);
    byte_row_t r;
    r.b = b;
    r.eos = eos;
    r.n = n;
    r.u = {u3, u2, u1, u0};
    byte_table.push_back(r);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos, input int typed_n,
                           input logic [3:0][15:0] typed_u);
    int gap;
    int n;
    logic [3:0][15:0] units;
    unit_beat_t beat;
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    end_of_string_i <= eos;
    do @(posedge clk_i); while (in_stall_o);
    n = decode_byte_in(b, eos, units);
    if (typed_n != Predicted) begin
      n = typed_n;
      units = typed_u;
    end
    for (int k = 0; k < n; k++) begin
      beat.code = units[k];
      beat.last = (k == n - 1);
      pending_units.push_back(beat);
    end
    bytes_sent++;
    if (eos) strings_sent++;
  endtask

  task automatic add_char();
    int kind;
    kind = int'($urandom_range(0, 99));
    if (kind < 40) begin
      str_bytes.push_back(rand_byte(1, 127));
    end else if (kind < 60) begin
      str_bytes.push_back(rand_byte(8'hC0, 8'hDF));
      str_bytes.push_back(rand_byte(8'h80, 8'hBF));
    end else if (kind < 80) begin
      str_bytes.push_back(rand_byte(8'hE0, 8'hEF));
      str_bytes.push_back(rand_byte(8'h80, 8'hBF));
      str_bytes.push_back(rand_byte(8'h80, 8'hBF));
    end else if (kind < 87) begin
      str_bytes.push_back(rand_byte(8'hF0, 8'hF7));
      repeat (3) str_bytes.push_back(rand_byte(8'h80, 8'hBF));
    end else if (kind < 95) begin
      str_bytes.push_back(rand_byte(1, 255));
    end else begin
      // truncated sequence
      str_bytes.push_back(rand_byte(8'hC0, 8'hEF));
    end
  endtask

  task automatic build_string();
    int nchars;
    str_bytes.delete();
    if ($urandom_range(0, 99) < 15) begin
      str_bytes.push_back(BomByte0);
      str_bytes.push_back(BomByte1);
      str_bytes.push_back(BomByte2);
    end
    nchars = ($urandom_range(0, 9) == 0) ? int'($urandom_range(8, 20))
                                         : int'($urandom_range(1, 6));
    repeat (nchars) add_char();
  endtask

  initial begin : out_stall_gen
    int len;
    out_stall_i = 1'b0;
    forever begin
      len = idle_len();
      if (len > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (len - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_units.size() == 0) begin
        $error("unexpected code unit: code_unit %h last_of_run %b",
               code_unit_o, last_of_run_o);
        errors++;
      end else begin
        want = pending_units.pop_front();
        if (code_unit_o !== want.code) begin
          $error("code_unit: expected %h, got %h", want.code, code_unit_o);
          errors++;
        end
        if (last_of_run_o !== want.last) begin
          $error("last_of_run: expected %b, got %b", want.last, last_of_run_o);
          errors++;
        end
        units_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("no beat moved for %0d cycles", IdleLimit);
      $display("FAIL utf8_to_ucs2_stream_decoder_top");
      $finish;
    end
  end

  initial begin : stimulus
    int directed_rows;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_byte_i = 8'h00;
    end_of_string_i = 1'b0;
    held0 = 8'h00;
    held1 = 8'h00;
    held_cnt = 2'd0;
    bom_armed = 1'b1;

    add_row(8'h01, 1'b1, 2, 16'h0001, TermUnit, 16'h0, 16'h0);
    add_row(8'hEF, 1'b0, 0, 16'h0, 16'h0, 16'h0, 16'h0);
    add_row(8'hBB, 1'b0, 0, 16'h0, 16'h0, 16'h0, 16'h0);
    add_row(8'hBF, 1'b0, 0, 16'h0, 16'h0, 16'h0, 16'h0);
    add_row(8'h7F, 1'b1, 2, 16'h007F, TermUnit, 16'h0, 16'h0);
    add_row(8'hFF, 1'b0, 0, 16'h0, 16'h0, 16'h0, 16'h0);
    add_row(8'hFF, 1'b0, 0, 16'h0, 16'h0, 16'h0, 16'h0);
    add_row(8'hFF, 1'b1, 4, QMark, QMark, QMark, TermUnit);
    add_row(8'hC3, 1'b0, Predicted, 16'h0, 16'h0, 16'h0, 16'h0);
    add_row(8'hA9, 1'b1, Predicted, 16'h0, 16'h0, 16'h0, 16'h0);
    add_row(8'hE2, 1'b0, Predicted, 16'h0, 16'h0, 16'h0, 16'h0);
    add_row(8'h82, 1'b0, Predicted, 16'h0, 16'h0, 16'h0, 16'h0);
    add_row(8'hAC, 1'b1, Predicted, 16'h0, 16'h0, 16'h0, 16'h0);
    add_row(8'h61, 1'b0, Predicted, 16'h0, 16'h0, 16'h0, 16'h0);
    add_row(8'hEF, 1'b0, Predicted, 16'h0, 16'h0, 16'h0, 16'h0);
    add_row(8'hBB, 1'b0, Predicted, 16'h0, 16'h0, 16'h0, 16'h0);
    add_row(8'hBF, 1'b1, Predicted, 16'h0, 16'h0, 16'h0, 16'h0);
    add_row(8'hE4, 1'b1, Predicted, 16'h0, 16'h0, 16'h0, 16'h0);
    add_row(8'hEF, 1'b0, Predicted, 16'h0, 16'h0, 16'h0, 16'h0);
    add_row(8'hBB, 1'b0, Predicted, 16'h0, 16'h0, 16'h0, 16'h0);
    add_row(8'h80, 1'b1, Predicted, 16'h0, 16'h0, 16'h0, 16'h0);
    add_row(8'h80, 1'b0, Predicted, 16'h0, 16'h0, 16'h0, 16'h0);
    add_row(8'hF0, 1'b0, Predicted, 16'h0, 16'h0, 16'h0, 16'h0);
    add_row(8'hF8, 1'b1, Predicted, 16'h0, 16'h0, 16'h0, 16'h0);
    directed_rows = byte_table.size();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (byte_table[i])
      send_byte(byte_table[i].b, byte_table[i].eos, byte_table[i].n, byte_table[i].u);

    while (bytes_sent < directed_rows + RandomBytes) begin
      quiet_phase = ($urandom_range(0, 3) == 0);
      build_string();
      foreach (str_bytes[i])
        send_byte(str_bytes[i], i == str_bytes.size() - 1, Predicted, '0);
    end
    quiet_phase = 1'b0;

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_units.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d bytes in %0d strings (%0d table rows, rest random UTF-8 and noise)",
             bytes_sent, strings_sent, directed_rows);
    $display("%0d code units checked, %0d mismatches", units_checked, errors);
    if (errors == 0)
      $display("PASS utf8_to_ucs2_stream_decoder_top");
    else
      $display("FAIL utf8_to_ucs2_stream_decoder_top");
    $finish;
  end

endmodule
